// File: rtl/lcpe_pkg.sv
// Shared types, constants and helper functions for the layer compositor.
// Depends on nothing; every other file of the block but lcpe_ram uses it.
`default_nettype none

package lcpe_pkg;

    localparam int FIELD_LAYERS = 6;
    localparam int COLOR_W      = 8;
    localparam int PRI_W        = 8;
    localparam int LAYERS_W     = FIELD_LAYERS * COLOR_W;
    localparam int BYTE_W       = 8;
    localparam int CHANNELS     = 3;
    localparam int RGB_W        = CHANNELS * BYTE_W;
    localparam int RGB565_W     = 16;
    localparam int INDEX_W      = 8;
    localparam int BRIGHT_W     = 5;
    localparam int TINT_W       = 8;
    localparam int PROD_W       = BYTE_W + BRIGHT_W;
    localparam int RECIP_W      = 16;
    localparam int QPROD_W      = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT  = 20;
    localparam int SUM_W        = BYTE_W + 2;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;

    // Rounded-up reciprocal of 31 scaled by 2^20; exact for products up to 255 * 31.
    localparam logic [RECIP_W-1:0]  RECIP_31     = 16'd33826;
    localparam logic [BRIGHT_W-1:0] BRIGHT_UNITY = 5'd31;
    localparam logic [BYTE_W-1:0]   BYTE_MAX     = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_HIGH  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_MID   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_LOW   = 8'd3;

    typedef enum logic
    {
        OP_COMPOSITE     = 1'b0,
        OP_PALETTE_WRITE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic               visible;
        logic [COLOR_W-1:0] color;
        logic [PRI_W-1:0]   pri;
    } lane_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] color;
        logic [PRI_W-1:0]   pri;
    } winner_t;

    // Palette entries hold blue in the high byte and red in the low byte.
    function automatic logic [RGB_W-1:0] expand565(input logic [RGB565_W-1:0] w);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = w[15:11];
        g6 = w[10:5];
        b5 = w[4:0];
        return {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    endfunction

    function automatic logic [RGB_W-1:0] gray_entry(input logic [COLOR_W-1:0] c);
        return {c, c, c};
    endfunction

endpackage

`default_nettype wire

// File: rtl/lcpe_item_if.sv
// Input channel of the compositor: one pixel or one palette write per beat.
// Depends on lcpe_pkg for field widths.
`default_nettype none

interface lcpe_item_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [lcpe_pkg::LAYERS_W-1:0]      layer_colors;
    logic [lcpe_pkg::LAYERS_W-1:0]      layer_priorities;
    logic [lcpe_pkg::FIELD_LAYERS-1:0]  layer_alpha_nonzero;
    logic [lcpe_pkg::INDEX_W-1:0]       palette_index;
    logic [lcpe_pkg::RGB565_W-1:0]      palette_rgb565;

    modport source (output valid, operation, layer_colors, layer_priorities,
                    layer_alpha_nonzero, palette_index, palette_rgb565,
                    input ready);
    modport sink (input valid, operation, layer_colors, layer_priorities,
                  layer_alpha_nonzero, palette_index, palette_rgb565,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/lcpe_result_if.sv
// Result channel of the compositor: one shaded pixel per beat.
// Depends on lcpe_pkg for field widths.
`default_nettype none

interface lcpe_result_if;
    logic                        valid;
    logic                        ready;
    logic [lcpe_pkg::RGB_W-1:0]  pixel_rgb;
    logic [lcpe_pkg::PRI_W-1:0]  top_priority;

    modport source (output valid, pixel_rgb, top_priority, input ready);
    modport sink (input valid, pixel_rgb, top_priority, output ready);
endinterface

`default_nettype wire

// File: rtl/lcpe_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on lcpe_pkg for field widths.
`default_nettype none

interface lcpe_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lcpe_pkg::CFG_INDEX_W-1:0]  index;
    logic [lcpe_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/layer_composite_palette_effects_unit.sv
// Priority layer compositor with palette lookup, brightness and tint.
// Takes one beat per cycle while the result channel is not stalled.
// Stages: lane merge, palette RAM read, brightness multiply, divide-tint-clamp into the output.
// Reset clears the pipeline and sets brightness 31 and zero tints; the palette reads
// as a gray ramp through per-entry valid bits until each entry is written.
`default_nettype none

module layer_composite_palette_effects_unit #(
    parameter int LAYER_COUNT   = 6,
    parameter int PALETTE_DEPTH = 256
) (
    input wire logic      clk,
    input wire logic      rst_n,
    lcpe_item_if.sink     pixels,
    lcpe_result_if.source results,
    lcpe_cfg_if.sink      cfg
);
    import lcpe_pkg::*;

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [BRIGHT_W-1:0]   brightness_reg;
    logic [TINT_W-1:0]     tint_high_reg;
    logic [TINT_W-1:0]     tint_mid_reg;
    logic [TINT_W-1:0]     tint_low_reg;

    lane_t                 lanes [LAYER_COUNT];
    winner_t               winner;
    logic                  in_fire;

    logic                  s1_valid_reg;
    logic                  s1_write_reg;
    logic [COLOR_W-1:0]    s1_color_reg;
    logic [PRI_W-1:0]      s1_pri_reg;
    logic [RGB_W-1:0]      s1_wdata_reg;
    logic                  s1_adv;
    logic                  s1_in_range;
    logic [ADDR_W-1:0]     s1_addr;

    logic [PALETTE_DEPTH-1:0] pal_valid_reg;
    logic                  ram_we;
    logic                  ram_re;
    logic [RGB_W-1:0]      ram_rdata;

    logic                  s2_valid_reg;
    logic [COLOR_W-1:0]    s2_color_reg;
    logic [PRI_W-1:0]      s2_pri_reg;
    logic                  s2_in_range_reg;
    logic                  s2_written_reg;
    logic                  s2_adv;
    logic [RGB_W-1:0]      s2_entry;

    logic                  s3_valid_reg;
    logic [PROD_W-1:0]     s3_prod_reg [CHANNELS];
    logic [PRI_W-1:0]      s3_pri_reg;
    logic                  s3_adv;
    logic [TINT_W-1:0]     tints [CHANNELS];
    logic [BYTE_W-1:0]     shaded [CHANNELS];

    logic                  out_valid_reg;
    logic [RGB_W-1:0]      out_rgb_reg;
    logic [PRI_W-1:0]      out_pri_reg;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_UNITY;
            tint_high_reg  <= '0;
            tint_mid_reg   <= '0;
            tint_low_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BRIGHTNESS: brightness_reg <= cfg.data[BRIGHT_W-1:0];
                REG_TINT_HIGH:  tint_high_reg  <= cfg.data[TINT_W-1:0];
                REG_TINT_MID:   tint_mid_reg   <= cfg.data[TINT_W-1:0];
                REG_TINT_LOW:   tint_low_reg   <= cfg.data[TINT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Lanes and merge.
    for (genvar k = 0; k < LAYER_COUNT; k++)
    begin : g_lane
        if (k < FIELD_LAYERS)
        begin : g_field
            lcpe_lane u_lane (
                .color         (pixels.layer_colors[COLOR_W*k +: COLOR_W]),
                .pri           (pixels.layer_priorities[PRI_W*k +: PRI_W]),
                .alpha_nonzero (pixels.layer_alpha_nonzero[k]),
                .lane          (lanes[k])
            );
        end
        else
        begin : g_empty
            lcpe_lane u_lane (
                .color         ('0),
                .pri           ('0),
                .alpha_nonzero (1'b0),
                .lane          (lanes[k])
            );
        end
    end

    lcpe_merge #(
        .LANES (LAYER_COUNT)
    ) u_merge (
        .lanes  (lanes),
        .winner (winner)
    );

    // Stage 1: merged winner or palette write.
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign in_fire      = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixels.ready)
        begin
            s1_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_write_reg <= (op_t'(pixels.operation) == OP_PALETTE_WRITE);
            if (op_t'(pixels.operation) == OP_PALETTE_WRITE)
            begin
                s1_color_reg <= pixels.palette_index;
                s1_pri_reg   <= '0;
            end
            else
            begin
                s1_color_reg <= winner.color;
                s1_pri_reg   <= winner.pri;
            end
            s1_wdata_reg <= expand565(pixels.palette_rgb565);
        end
    end

    assign s1_adv      = s1_valid_reg && (s1_write_reg || !s2_valid_reg || s2_adv);
    assign s1_in_range = {1'b0, s1_color_reg} < (COLOR_W + 1)'(PALETTE_DEPTH);
    assign s1_addr     = s1_color_reg[ADDR_W-1:0];
    assign ram_we      = s1_adv && s1_write_reg && s1_in_range;
    assign ram_re      = s1_adv && !s1_write_reg;

    lcpe_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (s1_wdata_reg),
        .re    (ram_re),
        .raddr (s1_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            pal_valid_reg[s1_addr] <= 1'b1;
        end
    end

    // Stage 2: palette entry available.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_valid_reg || s2_adv)
        begin
            s2_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s2_color_reg    <= s1_color_reg;
            s2_pri_reg      <= s1_pri_reg;
            s2_in_range_reg <= s1_in_range;
            s2_written_reg  <= pal_valid_reg[s1_addr];
        end
    end

    always_comb
    begin
        if (!s2_in_range_reg)
        begin
            s2_entry = '0;
        end
        else if (s2_written_reg)
        begin
            s2_entry = ram_rdata;
        end
        else
        begin
            s2_entry = gray_entry(s2_color_reg);
        end
    end

    assign s2_adv = s2_valid_reg && (!s3_valid_reg || s3_adv);

    // Stage 3: brightness products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (!s3_valid_reg || s3_adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                s3_prod_reg[i] <= {{BRIGHT_W{1'b0}}, s2_entry[BYTE_W*i +: BYTE_W]}
                                * {{BYTE_W{1'b0}}, brightness_reg};
            end
            s3_pri_reg <= s2_pri_reg;
        end
    end

    assign tints[0] = tint_low_reg;
    assign tints[1] = tint_mid_reg;
    assign tints[2] = tint_high_reg;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_shade
        lcpe_shade u_shade (
            .prod   (s3_prod_reg[c]),
            .tint   (tints[c]),
            .shaded (shaded[c])
        );
    end

    assign s3_adv = s3_valid_reg && (!out_valid_reg || results.ready);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            out_rgb_reg <= {shaded[2], shaded[1], shaded[0]};
            out_pri_reg <= s3_pri_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.pixel_rgb    = out_rgb_reg;
    assign results.top_priority = out_pri_reg;

    // A palette write leaves the pipeline after stage 1 and never reaches stage 2.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_write_reg && (!s2_valid_reg || s2_adv)) |=> !s2_valid_reg)
        else $error("palette write beat entered the read stage");

    // A written palette entry is marked valid on the following cycle.
    a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> pal_valid_reg[$past(s1_addr)])
        else $error("palette write did not set the entry valid bit");

    // A stalled product stage holds its contents.
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_adv) |=> (s3_valid_reg && $stable(s3_pri_reg)
                                       && $stable(s3_prod_reg[0])))
        else $error("product stage changed while stalled");

endmodule

`default_nettype wire

// File: rtl/lcpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lcpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// File: rtl/lcpe_lane.sv
// One compositor lane: decides whether a single layer takes part in the pixel.
// Depends on lcpe_pkg for the lane record.
`default_nettype none

module lcpe_lane (
    input  wire logic [lcpe_pkg::COLOR_W-1:0] color,
    input  wire logic [lcpe_pkg::PRI_W-1:0]   pri,
    input  wire logic                         alpha_nonzero,
    output lcpe_pkg::lane_t                   lane
);
    import lcpe_pkg::*;

    always_comb
    begin
        lane.visible = (color != '0) && alpha_nonzero;
        lane.color   = color;
        lane.pri     = pri;
    end
endmodule

`default_nettype wire

// File: rtl/lcpe_merge.sv
// Merges the lane results: the last visible layer whose priority reaches the running top wins.
// Depends on lcpe_pkg; the backdrop (color 0, priority 0) wins when no lane is visible.
`default_nettype none

module lcpe_merge #(
    parameter int LANES = 6
) (
    input  lcpe_pkg::lane_t   lanes [LANES],
    output lcpe_pkg::winner_t winner
);
    import lcpe_pkg::*;

    always_comb
    begin
        winner = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (lanes[k].visible && (lanes[k].pri >= winner.pri))
            begin
                winner.color = lanes[k].color;
                winner.pri   = lanes[k].pri;
            end
        end
    end
endmodule

`default_nettype wire

// File: rtl/lcpe_shade.sv
// Finishes one color byte: divides the brightness product by 31, adds the tint and clamps.
// Depends on lcpe_pkg for widths and the reciprocal constant.
`default_nettype none

module lcpe_shade (
    input  wire logic        [lcpe_pkg::PROD_W-1:0] prod,
    input  wire logic signed [lcpe_pkg::TINT_W-1:0] tint,
    output logic             [lcpe_pkg::BYTE_W-1:0] shaded
);
    import lcpe_pkg::*;

    logic        [QPROD_W-1:0] qprod;
    logic        [BYTE_W-1:0]  quotient;
    logic signed [SUM_W-1:0]   sum;

    always_comb
    begin
        qprod    = QPROD_W'(prod) * QPROD_W'(RECIP_31);
        quotient = qprod[RECIP_SHIFT +: BYTE_W];
        sum      = $signed({2'b00, quotient}) + $signed({{2{tint[TINT_W-1]}}, tint});
        if (sum[SUM_W-1])
        begin
            shaded = '0;
        end
        else if (sum[SUM_W-2])
        begin
            shaded = BYTE_MAX;
        end
        else
        begin
            shaded = sum[BYTE_W-1:0];
        end
    end
endmodule

`default_nettype wire
